### src/lps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lps_pkg;

	// Field widths.
	localparam int unsigned PeriodW  = 16;
	localparam int unsigned CountW   = 17;
	localparam int unsigned PatW     = 3;
	localparam int unsigned LedW     = 3;
	localparam int unsigned StepCntW = 6;
	localparam int unsigned SosPosW  = 4;
	localparam int unsigned RegIdxW  = 3;
	localparam int unsigned NumRegs  = 8;

	localparam logic [PeriodW-1:0] INITIAL_PERIOD_MS = 16'd500;

	// Heartbeat and count patterns wrap their step counter at 40.
	localparam logic [StepCntW-1:0] CYCLE_LAST = 6'd39;
	// The SOS word has nine symbols; bit i is set when symbol i is a dot.
	localparam logic [SosPosW-1:0] SOS_LAST    = 4'd8;
	localparam logic [8:0]         SOS_DOT_MAP = 9'b111_000_111;

	// Item kinds.
	localparam logic MODE_TICK  = 1'b0;
	localparam logic MODE_FORCE = 1'b1;

	typedef enum logic [PatW-1:0] {
		PAT_OFF       = 3'd0,
		PAT_SLOW      = 3'd1,
		PAT_FAST      = 3'd2,
		PAT_HEARTBEAT = 3'd3,
		PAT_SOS       = 3'd4,
		PAT_COUNT     = 3'd5
	} pattern_t;

	typedef enum logic [RegIdxW-1:0] {
		REG_SLOW      = 3'd0,
		REG_FAST      = 3'd1,
		REG_HEARTBEAT = 3'd2,
		REG_RAINBOW   = 3'd3,
		REG_DOT       = 3'd4,
		REG_DASH      = 3'd5,
		REG_SOS_PAUSE = 3'd6,
		REG_ADVANCE   = 3'd7
	} cfg_reg_t;

	typedef logic [PeriodW-1:0] reg_word_t;

	localparam reg_word_t REG_RESET [NumRegs] = '{
		16'd1000, 16'd200, 16'd100, 16'd300, 16'd200, 16'd600, 16'd1000, 16'd50
	};

	// Heartbeat lights LED three on phases 0, 1, 3 and 4 of each ten steps.
	function automatic logic heartbeat_on(input logic [StepCntW-1:0] cnt);
		logic [StepCntW-1:0] v;
		v = cnt;
		if (v >= 6'd40) v = v - 6'd40;
		if (v >= 6'd20) v = v - 6'd20;
		if (v >= 6'd10) v = v - 6'd10;
		return (v == 6'd0) || (v == 6'd1) || (v == 6'd3) || (v == 6'd4);
	endfunction

	function automatic logic [StepCntW-1:0] cycle_next(input logic [StepCntW-1:0] cnt);
		return (cnt >= CYCLE_LAST) ? '0 : cnt + 6'd1;
	endfunction

endpackage

`default_nettype wire

### src/lps_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Input items: a millisecond tick or a forced pattern change.
interface lps_item_if import lps_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            mode;
	logic [PatW-1:0] pattern_sel;

	modport source (output valid, mode, pattern_sel, input ready);
	modport sink   (input valid, mode, pattern_sel, output ready);
endinterface

// Result items, one for each input item.
interface lps_result_if import lps_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [LedW-1:0] leds;
	logic [PatW-1:0] pattern;
	logic            stepped;
	logic            auto_advanced;

	modport source (output valid, leds, pattern, stepped, auto_advanced, input ready);
	modport sink   (input valid, leds, pattern, stepped, auto_advanced, output ready);
endinterface

// Register writes.
interface lps_cfg_if import lps_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [RegIdxW-1:0] index;
	logic [PeriodW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/led_pattern_sequencer.sv
// LED pattern sequencer.
// The item channel carries either a one millisecond tick (mode 0) or a
// forced change to pattern_sel (mode 1). Every accepted item yields exactly
// one transfer on the result channel with the LED levels, the pattern in
// force, and flags telling whether the tick took a pattern step and whether
// that step moved on to the next pattern.
// The cfg channel writes the eight 16-bit period and step registers; it is
// always ready and should only be used while the block is idle.
// An accepted item waits in the input register, then passes through the
// step logic into the result register. One item is taken every cycle while
// the result channel does not stall; the sequencer state is updated in the
// same cycle that the result register loads, so back-to-back items see
// each other's effect.
// When the receiver stalls, the result register holds its transfer and the
// input register keeps one more item, after which item.ready drops.
// Reset (arst_n low) restores the register defaults, starts on slow blink
// with a 500 ms countdown, LEDs off, and empties both stages.
`timescale 1ns / 1ps
`default_nettype none

module led_pattern_sequencer import lps_pkg::*; (
	input wire logic   clk,
	input wire logic   arst_n,
	lps_item_if.sink   item,
	lps_result_if.source result,
	lps_cfg_if.sink    cfg
);

	// Configuration registers.
	reg_word_t regs_q [NumRegs];

	// Input stage.
	logic            valid_s1;
	logic            mode_s1;
	logic [PatW-1:0] pattern_sel_s1;

	// Sequencer state.
	pattern_t            pattern_q;
	logic [StepCntW-1:0] step_count_q;
	logic                blink_q;
	logic [SosPosW-1:0]  sos_pos_q;
	logic [PeriodW-1:0]  step_total_q;
	logic [PeriodW-1:0]  period_q;
	logic [CountW-1:0]   countdown_q;
	logic [LedW-1:0]     leds_q;

	// Next state from the step logic.
	pattern_t            pattern_n;
	logic [StepCntW-1:0] step_count_n;
	logic                blink_n;
	logic [SosPosW-1:0]  sos_pos_n;
	logic [PeriodW-1:0]  step_total_n;
	logic [PeriodW-1:0]  period_n;
	logic [CountW-1:0]   countdown_n;
	logic [LedW-1:0]     leds_n;
	logic                stepped_n;
	logic                advanced_n;

	// Result register.
	logic            out_valid_q;
	logic [PatW-1:0] out_pattern_q;
	logic [LedW-1:0] out_leds_q;
	logic            out_stepped_q;
	logic            out_advanced_q;

	logic advance;
	logic in_xfer;

	// The input stage moves on whenever the result register is free or being emptied.
	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign in_xfer    = item.valid && item.ready;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= REG_RESET;
		end else if (cfg.valid) begin
			regs_q[cfg.index] <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mode_s1        <= item.mode;
			pattern_sel_s1 <= item.pattern_sel;
		end
	end

	// One pass of the sequencer for the item in the input stage.
	always_comb begin
		logic [PeriodW-1:0] extra;
		logic [PeriodW-1:0] limit;
		logic               dot;

		pattern_n    = pattern_q;
		step_count_n = step_count_q;
		blink_n      = blink_q;
		sos_pos_n    = sos_pos_q;
		step_total_n = step_total_q;
		period_n     = period_q;
		countdown_n  = countdown_q;
		leds_n       = leds_q;
		stepped_n    = 1'b0;
		advanced_n   = 1'b0;
		extra        = '0;
		limit        = (regs_q[REG_ADVANCE] == '0) ? 16'd1 : regs_q[REG_ADVANCE];
		dot          = SOS_DOT_MAP[sos_pos_q];

		if (mode_s1 == MODE_FORCE) begin
			// Codes 6 and 7 name no pattern and leave everything alone.
			if (pattern_sel_s1 <= PAT_COUNT) begin
				pattern_n    = pattern_t'(pattern_sel_s1);
				step_count_n = '0;
				blink_n      = 1'b0;
				countdown_n  = {1'b0, period_q};
			end
		end else if (countdown_q <= 17'd1) begin
			stepped_n = 1'b1;
			case (pattern_q)
				PAT_OFF: begin
					leds_n   = '0;
					period_n = regs_q[REG_SLOW];
				end
				PAT_SLOW: begin
					blink_n  = !blink_q;
					leds_n   = {2'b00, !blink_q};
					period_n = regs_q[REG_SLOW];
				end
				PAT_FAST: begin
					blink_n  = !blink_q;
					leds_n   = {1'b0, !blink_q, 1'b0};
					period_n = regs_q[REG_FAST];
				end
				PAT_HEARTBEAT: begin
					leds_n       = heartbeat_on(step_count_q) ? 3'b100 : 3'b000;
					step_count_n = cycle_next(step_count_q);
					period_n     = regs_q[REG_HEARTBEAT];
				end
				PAT_SOS: begin
					// Dots light every LED, dashes leave them dark.
					leds_n   = dot ? 3'b111 : 3'b000;
					period_n = dot ? regs_q[REG_DOT] : regs_q[REG_DASH];
					if (sos_pos_q >= SOS_LAST) begin
						sos_pos_n = '0;
						extra     = regs_q[REG_SOS_PAUSE];
					end else begin
						sos_pos_n = sos_pos_q + 4'd1;
					end
				end
				default: begin
					leds_n       = step_count_q[LedW-1:0];
					step_count_n = cycle_next(step_count_q);
					period_n     = regs_q[REG_RAINBOW];
				end
			endcase
			countdown_n  = {1'b0, period_n} + {1'b0, extra};
			step_total_n = step_total_q + 16'd1;
			if (step_total_n >= limit) begin
				step_total_n = '0;
				advanced_n   = 1'b1;
				pattern_n    = (pattern_q == PAT_COUNT) ? PAT_OFF
				                                        : pattern_t'(pattern_q + 3'd1);
				step_count_n = '0;
				blink_n      = 1'b0;
			end
		end else begin
			countdown_n = countdown_q - 17'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q    <= PAT_SLOW;
			step_count_q <= '0;
			blink_q      <= 1'b0;
			sos_pos_q    <= '0;
			step_total_q <= '0;
			period_q     <= INITIAL_PERIOD_MS;
			countdown_q  <= {1'b0, INITIAL_PERIOD_MS};
			leds_q       <= '0;
		end else if (advance) begin
			pattern_q    <= pattern_n;
			step_count_q <= step_count_n;
			blink_q      <= blink_n;
			sos_pos_q    <= sos_pos_n;
			step_total_q <= step_total_n;
			period_q     <= period_n;
			countdown_q  <= countdown_n;
			leds_q       <= leds_n;
		end
	end

	// The result register loads together with the state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_leds_q     <= leds_n;
			out_pattern_q  <= pattern_n;
			out_stepped_q  <= stepped_n;
			out_advanced_q <= advanced_n;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.leds          = out_leds_q;
	assign result.pattern       = out_pattern_q;
	assign result.stepped       = out_stepped_q;
	assign result.auto_advanced = out_advanced_q;

endmodule

`default_nettype wire

### src/lps_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lps_checker import lps_pkg::*; (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            res_valid,
	input wire logic            res_ready,
	input wire logic [LedW-1:0] res_leds,
	input wire logic [PatW-1:0] res_pattern,
	input wire logic            res_stepped,
	input wire logic            res_advanced
);

	// A stalled result keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=>
			$stable(res_leds) && $stable(res_pattern) && $stable(res_stepped)
			&& $stable(res_advanced))
	else $error("result payload changed while stalled");

	// Only a step can move on to the next pattern.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_advanced |-> res_stepped)
	else $error("auto advance without a step");

	// The reported pattern is always one of the six.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_pattern <= PAT_COUNT)
	else $error("pattern out of range");

	// A step of the off pattern that stays there leaves every LED dark.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stepped && !res_advanced && res_pattern == PAT_OFF
			|-> res_leds == 3'b000)
	else $error("off pattern lit an LED");

	// A heartbeat step lights LED three or nothing.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stepped && !res_advanced && res_pattern == PAT_HEARTBEAT
			|-> res_leds == 3'b000 || res_leds == 3'b100)
	else $error("heartbeat lit a wrong LED");

endmodule

bind led_pattern_sequencer lps_checker u_lps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.res_leds     (result.leds),
	.res_pattern  (result.pattern),
	.res_stepped  (result.stepped),
	.res_advanced (result.auto_advanced)
);

`default_nettype wire
